// File: design/apse_pkg.sv
// Package for the asymmetric peak shape evaluator: fixed-point constants,
// divider geometry, the side-band struct and the 2^-f table entry function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package apse_pkg;

  localparam int EXP_TABLE_DEPTH_DEF = 256;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_W = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd4;

  localparam logic MODE_LORENTZ = 1'b0;
  localparam logic MODE_SECH2   = 1'b1;

  // shared divider: quotient, numerator and denominator widths
  localparam int DIV_QW = 33;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 49;

  typedef struct packed {
    logic [31:0] height;
    logic        mode;
  } side_t;

  // truncating 17-term series of exp(-y), y in Q.32
  function automatic logic [32:0] exp_entry(input logic [63:0] y);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 32;
    sum  = term;
    term = ((term * y) >> 32) / 1;  sum = sum - term;
    term = ((term * y) >> 32) / 2;  sum = sum + term;
    term = ((term * y) >> 32) / 3;  sum = sum - term;
    term = ((term * y) >> 32) / 4;  sum = sum + term;
    term = ((term * y) >> 32) / 5;  sum = sum - term;
    term = ((term * y) >> 32) / 6;  sum = sum + term;
    term = ((term * y) >> 32) / 7;  sum = sum - term;
    term = ((term * y) >> 32) / 8;  sum = sum + term;
    term = ((term * y) >> 32) / 9;  sum = sum - term;
    term = ((term * y) >> 32) / 10; sum = sum + term;
    term = ((term * y) >> 32) / 11; sum = sum - term;
    term = ((term * y) >> 32) / 12; sum = sum + term;
    term = ((term * y) >> 32) / 13; sum = sum - term;
    term = ((term * y) >> 32) / 14; sum = sum + term;
    term = ((term * y) >> 32) / 15; sum = sum - term;
    term = ((term * y) >> 32) / 16; sum = sum + term;
    return sum[32:0];
  endfunction

endpackage
`default_nettype wire

// File: design/apse_if.sv
// Stream interfaces for sample positions and model values.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface apse_pos_if;
  logic        valid;
  logic        ready;
  logic [31:0] position;
  modport source (output valid, output position, input ready);
  modport sink (input valid, input position, output ready);
endinterface

interface apse_val_if;
  logic        valid;
  logic        ready;
  logic [31:0] model_value;
  modport source (output valid, output model_value, input ready);
  modport sink (input valid, input model_value, output ready);
endinterface
`default_nettype wire

// File: design/apse_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on apse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module apse_div import apse_pkg::*; #(
  parameter int QW = DIV_QW,
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire side_t         in_side,
  output logic               out_valid,
  output logic [QW-1:0]      quot,
  output side_t              out_side
);

  logic          v  [1:QW];
  logic [DW-1:0] r  [1:QW];
  logic [QW-1:0] nb [1:QW];
  logic [DW-1:0] d  [1:QW];
  logic [QW-1:0] q  [1:QW];
  side_t         sd [1:QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic          vc;
    logic [DW-1:0] rc;
    logic [QW-1:0] nc;
    logic [DW-1:0] dc;
    logic [QW-1:0] qc;
    side_t         sc;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign vc = in_valid;
      assign rc = DW'(num >> QW);
      assign nc = num[QW-1:0];
      assign dc = den;
      assign qc = '0;
      assign sc = in_side;
    end else begin : g_next
      assign vc = v[j];
      assign rc = r[j];
      assign nc = nb[j];
      assign dc = d[j];
      assign qc = q[j];
      assign sc = sd[j];
    end

    assign trial = {rc, nc[QW-1]};
    assign diff  = trial - {1'b0, dc};
    assign ge    = trial >= {1'b0, dc};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= vc;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[j+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nb[j+1] <= {nc[QW-2:0], 1'b0};
        q[j+1]  <= {qc[QW-2:0], ge};
        d[j+1]  <= dc;
        sd[j+1] <= sc;
      end
    end
  end

  assign out_valid = v[QW];
  assign quot      = q[QW];
  assign out_side  = sd[QW];

endmodule
`default_nettype wire

// File: design/asymmetric_peak_shape_eval_unit.sv
// Top level of the asymmetric peak shape evaluator (Lorentzian / sech^2).
// Depends on apse_pkg, apse_if and apse_div.
//
//   channel   dir  payload          notes
//   smp       in   position  [31:0] Q16.16 sample position
//   res       out  model_value[31:0] unsigned intensity
//   cfg_*     in   index/data       plain write, no read-back
//
// One word per cycle while res is not stalled; the bit-per-stage divider
// is shared by both shapes.
// Synchronous reset clears valid bits and configuration.
// A stall on res freezes every stage; smp.ready falls in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module asymmetric_peak_shape_eval_unit import apse_pkg::*; #(
  parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  apse_pos_if.sink                  smp,
  apse_val_if.source                res,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam int IW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int SW = 46 + IW;

  logic [31:0] peak_height, peak_centre, left_inv_width, right_inv_width;
  logic        shape_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_height     <= '0;
      peak_centre     <= '0;
      left_inv_width  <= '0;
      right_inv_width <= '0;
      shape_mode      <= MODE_LORENTZ;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEIGHT:  peak_height     <= cfg_data;
        REG_CENTRE:  peak_centre     <= cfg_data;
        REG_LEFT_W:  left_inv_width  <= cfg_data;
        REG_RIGHT_W: right_inv_width <= cfg_data;
        REG_MODE:    shape_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // 2^-f table
  logic [32:0] tab [0:EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [63:0] Y = (64'(g) * 64'(LN2_Q32)) / EXP_TABLE_DEPTH;
    assign tab[g] = exp_entry(Y);
  end
  assign tab[EXP_TABLE_DEPTH] = 33'd1 << 31;

  logic en;
  assign en        = !(res.valid && !res.ready);
  assign smp.ready = en;

  // stage 1: distance and width
  logic        v1;
  logic [31:0] d1, w1;
  side_t       s1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= smp.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (smp.position <= peak_centre) begin
        d1 <= peak_centre - smp.position;
        w1 <= left_inv_width;
      end else begin
        d1 <= smp.position - peak_centre;
        w1 <= right_inv_width;
      end
      s1 <= '{height: peak_height, mode: shape_mode};
    end
  end

  // stage 2: u, saturated
  logic        v2;
  logic [31:0] u2;
  side_t       s2;
  logic [63:0] wd;
  assign wd = w1 * d1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      u2 <= (wd[63:52] != '0) ? 32'hFFFF_FFFF : wd[51:20];
      s2 <= s1;
    end
  end

  // stage 3: u^2 and exponent argument
  logic        v3;
  logic [47:0] q3;
  logic [63:0] z3;
  side_t       s3;
  logic [63:0] uu;
  assign uu = u2 * u2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q3 <= uu[63:16];
      z3 <= {u2, 1'b0} * LOG2E_Q30;
      s3 <= s2;
    end
  end

  // stage 4: table index and interpolation weight
  logic          v4, kbig4;
  logic [4:0]    ksh4;
  logic [IW-1:0] idx4;
  logic [31:0]   rem4;
  logic [47:0]   q4;
  side_t         s4;
  logic [SW-1:0] sfr;
  assign sfr = SW'(z3[45:0]) * SW'(EXP_TABLE_DEPTH);
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      kbig4 <= z3[63:51] != '0;
      ksh4  <= z3[50:46];
      idx4  <= sfr[SW-1:46];
      rem4  <= sfr[45:14];
      q4    <= q3;
      s4    <= s3;
    end
  end

  // stage 5: table reads
  logic        v5, kbig5;
  logic [4:0]  ksh5;
  logic [32:0] a5, b5;
  logic [31:0] rem5;
  logic [47:0] q5;
  side_t       s5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a5    <= tab[idx4];
      b5    <= tab[idx4 + IW'(1)];
      kbig5 <= kbig4;
      ksh5  <= ksh4;
      rem5  <= rem4;
      q5    <= q4;
      s5    <= s4;
    end
  end

  // stage 6: interpolation
  logic        v6, kbig6;
  logic [4:0]  ksh6;
  logic [32:0] e6;
  logic [47:0] q6;
  side_t       s6;
  logic        dec;
  logic [32:0] ab;
  logic [64:0] ip;
  assign dec = a5 >= b5;
  assign ab  = dec ? (a5 - b5) : (b5 - a5);
  assign ip  = ab * rem5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e6    <= dec ? (a5 - ip[64:32]) : (a5 + ip[64:32]);
      kbig6 <= kbig5;
      ksh6  <= ksh5;
      q6    <= q5;
      s6    <= s5;
    end
  end

  // stage 7: divider operands
  logic              v7;
  logic [DIV_NW-1:0] n7;
  logic [DIV_DW-1:0] dn7;
  side_t             s7;
  logic [32:0]       tsh;
  logic [31:0]       t31;
  assign tsh = kbig6 ? '0 : (e6 >> (6'(ksh6) + 6'd1));
  assign t31 = (tsh > (33'd1 << 31)) ? 32'h8000_0000 : tsh[31:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (s6.mode == MODE_LORENTZ) begin
        n7  <= DIV_NW'({s6.height, 16'h0000});
        dn7 <= DIV_DW'(q6) + (DIV_DW'(1) << 16);
      end else begin
        n7  <= {t31, 32'h0000_0000};
        dn7 <= DIV_DW'(t31) + (DIV_DW'(1) << 31);
      end
      s7 <= s6;
    end
  end

  logic              vq;
  logic [DIV_QW-1:0] qq;
  side_t             sq;

  apse_div #(.QW(DIV_QW), .NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v7),
    .num      (n7),
    .den      (dn7),
    .in_side  (s7),
    .out_valid(vq),
    .quot     (qq),
    .out_side (sq)
  );

  // stage 8: 4p(1-p)
  logic        v8;
  logic [32:0] r8, qt8;
  side_t       s8;
  logic [32:0] pm;
  logic [65:0] pp;
  assign pm = (33'd1 << 32) - qq;
  assign pp = qq * pm;
  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= vq;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r8  <= pp[62:30];
      qt8 <= qq;
      s8  <= sq;
    end
  end

  // stage 9: scale by height in sech^2 mode; the Lorentzian quotient passes through
  logic        v9;
  logic [31:0] out9;
  logic [64:0] hr;
  assign hr = s8.height * r8;
  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out9 <= (s8.mode == MODE_LORENTZ) ? qt8[31:0] : hr[63:32];
    end
  end

  assign res.valid       = v9;
  assign res.model_value = out9;

`ifndef SYNTHESIS
  a_bound: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.model_value <= peak_height)
    else $error("model value above peak height");

  a_flat: assert property (@(posedge clk) disable iff (rst)
    (res.valid && left_inv_width == '0 && right_inv_width == '0)
      |-> res.model_value == peak_height)
    else $error("zero width does not give peak height");
`endif

endmodule
`default_nettype wire

// File: tb/apse_tb_if.sv
// Testbench-side copies of the stream interfaces are not needed: this file
// holds the value-checking class for the peak shape evaluator bench.
// Depends on apse_pkg.
`timescale 1ns / 1ps
class peak_value_board;
  bit [31:0] height, centre, left_w, right_w;
  bit        mode;
  bit [63:0] pow2_frac[0:256];
  bit [31:0] pending[$];
  int        errors;

  function new();
    bit [63:0] y, term, sum;
    for (int i = 0; i < 256; i++) begin
      y = (64'(i) * 64'(apse_pkg::LN2_Q32)) / 64'd256;
      term = 64'd1 << 32;
      sum = term;
      for (int n = 1; n <= 16; n++) begin
        term = ((term * y) >> 32) / 64'(n);
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      pow2_frac[i] = sum;
    end
    pow2_frac[256] = 64'd1 << 31;
    errors = 0;
  endfunction

  function void write_reg(bit [2:0] idx, bit [31:0] data);
    case (idx)
      apse_pkg::REG_HEIGHT:  height = data;
      apse_pkg::REG_CENTRE:  centre = data;
      apse_pkg::REG_LEFT_W:  left_w = data;
      apse_pkg::REG_RIGHT_W: right_w = data;
      apse_pkg::REG_MODE:    mode = data[0];
      default: ;
    endcase
  endfunction

  function bit [31:0] peak_at(bit [31:0] x);
    bit [63:0] d, w, u, q, v, z, k, s, idx, rem, a, b, e, t31, p, r, res;
    if (x <= centre) begin
      d = 64'(centre - x);
      w = 64'(left_w);
    end else begin
      d = 64'(x - centre);
      w = 64'(right_w);
    end
    u = (w * d) >> 20;
    if (u > 64'hFFFF_FFFF) u = 64'hFFFF_FFFF;
    if (mode == apse_pkg::MODE_LORENTZ) begin
      q = (u * u) >> 16;
      res = (64'(height) << 16) / ((64'd1 << 16) + q);
    end else begin
      v = u << 1;
      z = v * 64'(apse_pkg::LOG2E_Q30);
      k = z >> 46;
      s = (z & ((64'd1 << 46) - 1)) * 64'd256;
      idx = s >> 46;
      rem = (s & ((64'd1 << 46) - 1)) >> 14;
      if (k >= 32) return 32'd0;
      if (idx >= 256) idx = 255;
      a = pow2_frac[idx];
      b = pow2_frac[idx + 1];
      if (a >= b) e = a - (((a - b) * rem) >> 32);
      else e = a + (((b - a) * rem) >> 32);
      t31 = e >> (k + 1);
      if (t31 > (64'd1 << 31)) t31 = 64'd1 << 31;
      p = (t31 << 32) / ((64'd1 << 31) + t31);
      r = (p * ((64'd1 << 32) - p)) >> 30;
      res = (64'(height) * r) >> 32;
    end
    return res[31:0];
  endfunction

  function void note_position(bit [31:0] x);
    pending.push_back(peak_at(x));
  endfunction

  task report(string what, bit [31:0] got, bit [31:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    errors++;
  endtask

  task check_value(bit [31:0] got);
    bit [31:0] want;
    if (pending.size() == 0) begin
      report("unexpected word", got, 32'd0);
      return;
    end
    want = pending.pop_front();
    if (got !== want) report("model_value", got, want);
  endtask
endclass

// File: tb/tb.sv
// Top of the peak shape evaluator bench: clock, reset, stream drivers,
// config writes and the final verdict. Depends on apse_pkg, apse_if, the
// evaluator top level and the value-checking class file.
`timescale 1ns / 1ps
module tb;
  import apse_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  int hold_cycles = 0;
  bit calm = 0;

  apse_pos_if smp ();
  apse_val_if res ();
  peak_value_board board = new();

  asymmetric_peak_shape_eval_unit dut (
    .clk(clk), .rst(rst), .smp(smp), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // sink side: random stalls, plus a long hold-off on request
  initial begin
    res.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        res.ready <= 0;
        hold_cycles--;
      end else if (calm) res.ready <= 1;
      else res.ready <= (pick_gap() == 0);
    end
  end

  always @(posedge clk)
    if (!rst && res.valid && res.ready) board.check_value(res.model_value);

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 0;
    board.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic send_word(logic [31:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      smp.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    smp.valid <= 1;
    smp.position <= pos;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    board.note_position(pos);
    @(negedge clk);
  endtask

  task automatic drain();
    smp.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic load_shape(logic [31:0] h, logic [31:0] c, logic [31:0] lw,
                            logic [31:0] rw, logic m);
    write_cfg(REG_HEIGHT, h);
    write_cfg(REG_CENTRE, c);
    write_cfg(REG_LEFT_W, lw);
    write_cfg(REG_RIGHT_W, rw);
    write_cfg(REG_MODE, {31'd0, m});
  endtask

  function automatic logic [31:0] pick_width();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return $urandom_range(0, 32'h0000_3FFF);
      default: return $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  function automatic logic [31:0] pick_position(logic [31:0] c);
    logic [31:0] off;
    if ($urandom_range(0, 3) == 0) return $urandom;
    off = $urandom_range(0, 32'h00FF_FFFF) >> $urandom_range(0, 20);
    return $urandom_range(0, 1) ? c + off : c - off;
  endfunction

  task automatic directed_set(logic m);
    logic [31:0] pts[10];
    pts = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001,
            32'h7FFF_0000, 32'h8001_0000, 32'h8003_0000, 32'h7FF0_0000, 32'h8100_0000};
    load_shape(32'hFFFF_FFFF, 32'h8000_0000, 32'h0010_0000, 32'h0040_0000, m);
    foreach (pts[i]) send_word(pts[i]);
    drain();
  endtask

  initial begin
    logic [31:0] c;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    smp.valid = 0;
    smp.position = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_word(32'h1234_5678);
    drain();
    directed_set(MODE_LORENTZ);
    directed_set(MODE_SECH2);
    load_shape(32'd1000, 32'h0001_0000, 32'd0, 32'hFFFF_FFFF, MODE_SECH2);
    write_cfg(REG_SPARE, 32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'h0001_0000);
    send_word(32'h0001_0001);
    send_word(32'hFFFF_FFFF);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      c = (ph % 4 == 0) ? (ph % 8 == 0 ? 32'h0 : 32'hFFFF_FFFF) : $urandom;
      load_shape((ph % 3 == 0) ? 32'hFFFF_FFFF : $urandom, c, pick_width(),
                 pick_width(), ph[0]);
      calm = (ph == 3);
      if (ph == 5) hold_cycles = 300;
      for (int i = 0; i < 130; i++) begin
        if (i % 40 == 39) begin
          drain();
          write_cfg(REG_LEFT_W, pick_width());
          write_cfg(REG_RIGHT_W, pick_width());
        end
        send_word(pick_position(c));
      end
      drain();
    end
    calm = 0;

    if (board.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
